>>> rtl/core/khr_pkg.sv
package khr_pkg;

	// Widths of the item fields and of the membership word.
	localparam int unsigned KIND_W = 2;
	localparam int unsigned NODE_W = 6;
	localparam int unsigned MASK_W = 64;
	localparam int unsigned CNT_W  = 7;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// Control of the adjacency store for one cycle.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} adj_ctl_t;

	// Number of set bits in one byte.
	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + {3'd0, v[i]};
		end
		return n;
	endfunction

	// Index of the single set bit of a one-hot word.
	function automatic logic [NODE_W-1:0] encode_onehot(input logic [MASK_W-1:0] v);
		logic [NODE_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (v[i]) begin
				idx = idx | NODE_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> rtl/core/khr_adj_store.sv
module khr_adj_store import khr_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned IDX_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  adj_ctl_t          ctl,
	input  logic [IDX_W-1:0]  rd_addr_a,
	input  logic [IDX_W-1:0]  rd_addr_b,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [MASK_W-1:0] wr_data,
	output logic [MASK_W-1:0] rd_data_a,
	output logic [MASK_W-1:0] rd_data_b
);

	logic [MASK_W-1:0] rows_q [DEPTH];
	logic [DEPTH-1:0]  row_vld_q;
	logic [MASK_W-1:0] rd_a_s1;
	logic [MASK_W-1:0] rd_b_s1;
	logic              vld_a_s1;
	logic              vld_b_s1;

	// Row storage: one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			rows_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_a_s1 <= rows_q[rd_addr_a];
			rd_b_s1 <= rows_q[rd_addr_b];
		end
	end

	// A row that was never written since the last clear reads as empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			vld_a_s1  <= 1'b0;
			vld_b_s1  <= 1'b0;
		end else begin
			if (ctl.clr) begin
				row_vld_q <= '0;
			end else if (ctl.wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				vld_a_s1 <= row_vld_q[rd_addr_a];
				vld_b_s1 <= row_vld_q[rd_addr_b];
			end
		end
	end

	assign rd_data_a = vld_a_s1 ? rd_a_s1 : '0;
	assign rd_data_b = vld_b_s1 ? rd_b_s1 : '0;

endmodule

>>> rtl/core/keyframe_graph_hop_radius_unit.sv
// Timing: an edge add reads both rows, then writes row a and then row b; clear
// and rejected items answer through the registered done; a query is paced by the
// scan read port, one adjacency row per cycle, and the byte-wide member count.
// Throughput: one item at a time; busy is high until the result cycle, in which
// the next start can already be taken. Results are strobed by done for one cycle.
// Reset: arst_n clears the sequencer and all edges at once through row valid bits.
module keyframe_graph_hop_radius_unit import khr_pkg::*; #(
	parameter int unsigned NODES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [KIND_W-1:0] kind,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	input  logic [NODE_W-1:0] radius,
	output logic              done,
	output logic [MASK_W-1:0] member_mask,
	output logic [CNT_W-1:0]  member_count
);

	localparam int unsigned IDX_W = $clog2(NODES);
	localparam logic [NODE_W:0] NODES_LIM = (NODE_W+1)'(NODES);
	localparam logic [MASK_W-1:0] NODE_MASK =
		(NODES >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << NODES) - MASK_W'(1));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_WA,
		ST_EDGE_WB,
		ST_SCAN,
		ST_COUNT
	} state_t;

	state_t            state_q;
	logic [NODE_W-1:0] a_q;
	logic [NODE_W-1:0] b_q;
	logic [NODE_W-1:0] radius_q;
	logic [NODE_W-1:0] level_q;
	logic [MASK_W-1:0] members_q;
	logic [MASK_W-1:0] pending_q;
	logic [MASK_W-1:0] acc_q;
	logic              rd_s1;
	logic [MASK_W-1:0] cnt_sh_q;
	logic [CNT_W-1:0]  cnt_sum_q;
	logic [2:0]        byte_q;
	logic              done_q;
	logic [MASK_W-1:0] mask_q;
	logic [CNT_W-1:0]  count_q;

	adj_ctl_t          ctl;
	logic [IDX_W-1:0]  rd_addr_a;
	logic [IDX_W-1:0]  rd_addr_b;
	logic [IDX_W-1:0]  wr_addr;
	logic [MASK_W-1:0] wr_data;
	logic [MASK_W-1:0] rd_data_a;
	logic [MASK_W-1:0] rd_data_b;

	logic              take;
	logic              a_ok;
	logic              b_ok;
	logic [MASK_W-1:0] low_bit;
	logic [NODE_W-1:0] scan_idx;
	logic [MASK_W-1:0] acc_nxt;
	logic [MASK_W-1:0] new_nodes;
	logic [CNT_W-1:0]  cnt_nxt;

	assign take      = start && (state_q == ST_IDLE);
	assign a_ok      = {1'b0, node_a} < NODES_LIM;
	assign b_ok      = {1'b0, node_b} < NODES_LIM;
	assign low_bit   = pending_q & (~pending_q + MASK_W'(1));
	assign scan_idx  = encode_onehot(low_bit);
	assign acc_nxt   = rd_s1 ? (acc_q | rd_data_a) : acc_q;
	assign new_nodes = acc_q & NODE_MASK & ~members_q;
	assign cnt_nxt   = cnt_sum_q + CNT_W'(popcount8(cnt_sh_q[7:0]));

	// Store control: edge reads or clear on transfer, two row writes, frontier row reads.
	always_comb begin
		ctl       = '0;
		rd_addr_a = node_a[IDX_W-1:0];
		rd_addr_b = node_b[IDX_W-1:0];
		wr_addr   = a_q[IDX_W-1:0];
		wr_data   = rd_data_a | (MASK_W'(1) << b_q);
		unique case (state_q)
			ST_IDLE: begin
				if (take && kind == KIND_ADD && a_ok && b_ok && node_a != node_b) begin
					ctl.rd_en = 1'b1;
				end
				if (take && kind == KIND_CLEAR) begin
					ctl.clr = 1'b1;
				end
			end
			ST_EDGE_WA: begin
				ctl.wr_en = 1'b1;
			end
			ST_EDGE_WB: begin
				ctl.wr_en = 1'b1;
				wr_addr   = b_q[IDX_W-1:0];
				wr_data   = rd_data_b | (MASK_W'(1) << a_q);
			end
			ST_SCAN: begin
				if (pending_q != '0) begin
					ctl.rd_en = 1'b1;
					rd_addr_a = scan_idx[IDX_W-1:0];
				end
			end
			ST_COUNT: begin
			end
			default: begin
			end
		endcase
	end

	khr_adj_store #(
		.DEPTH (NODES),
		.IDX_W (IDX_W)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// Sequencer with the result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_s1     <= 1'b0;
			done_q    <= 1'b0;
			a_q       <= '0;
			b_q       <= '0;
			radius_q  <= '0;
			level_q   <= '0;
			members_q <= '0;
			pending_q <= '0;
			acc_q     <= '0;
			cnt_sh_q  <= '0;
			cnt_sum_q <= '0;
			byte_q    <= '0;
			mask_q    <= '0;
			count_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						a_q      <= node_a;
						b_q      <= node_b;
						radius_q <= radius;
						mask_q   <= '0;
						count_q  <= '0;
						case (kind)
							KIND_ADD: begin
								if (a_ok && b_ok && node_a != node_b) begin
									state_q <= ST_EDGE_WA;
								end else begin
									done_q <= 1'b1;
								end
							end
							KIND_QUERY: begin
								if (a_ok) begin
									members_q <= MASK_W'(1) << node_a;
									pending_q <= MASK_W'(1) << node_a;
									acc_q     <= '0;
									level_q   <= '0;
									rd_s1     <= 1'b0;
									cnt_sh_q  <= MASK_W'(1) << node_a;
									cnt_sum_q <= '0;
									byte_q    <= '0;
									state_q   <= (radius == '0) ? ST_COUNT : ST_SCAN;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_EDGE_WA: begin
					state_q <= ST_EDGE_WB;
				end
				ST_EDGE_WB: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					// One frontier row is fetched per cycle; the level closes once
					// all fetched rows have been merged.
					if (pending_q != '0) begin
						pending_q <= pending_q & ~low_bit;
						acc_q     <= acc_nxt;
						rd_s1     <= 1'b1;
					end else if (rd_s1) begin
						acc_q <= acc_nxt;
						rd_s1 <= 1'b0;
					end else begin
						members_q <= members_q | new_nodes;
						level_q   <= level_q + NODE_W'(1);
						acc_q     <= '0;
						pending_q <= new_nodes;
						if (new_nodes == '0 || (level_q + NODE_W'(1)) == radius_q) begin
							cnt_sh_q  <= members_q | new_nodes;
							cnt_sum_q <= '0;
							byte_q    <= '0;
							state_q   <= ST_COUNT;
						end
					end
				end
				ST_COUNT: begin
					// Member count, one byte of the mask per cycle.
					cnt_sh_q  <= cnt_sh_q >> 8;
					cnt_sum_q <= cnt_nxt;
					byte_q    <= byte_q + 3'd1;
					if (byte_q == 3'd7) begin
						mask_q  <= members_q;
						count_q <= cnt_nxt;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign member_mask  = mask_q;
	assign member_count = count_q;

endmodule

>>> rtl/core/khr_checker.sv
module khr_checker import khr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [MASK_W-1:0] member_mask,
	input logic [CNT_W-1:0]  member_count
);

	// Every accepted transfer leaves the block working or answering.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item produced neither busy nor a result");

	// A result only follows an accepted transfer or a busy cycle.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result without a preceding item");

	// An empty mask and a zero count go together.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((member_mask == '0) == (member_count == '0)))
		else $error("member count disagrees with an empty mask");

	// A single member means exactly one mask bit.
	a_single_member: assert property (@(posedge clk) disable iff (!arst_n)
		(done && member_count == CNT_W'(1)) |-> $onehot(member_mask))
		else $error("count of one without a one-hot mask");

endmodule

bind keyframe_graph_hop_radius_unit khr_checker u_khr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.member_mask  (member_mask),
	.member_count (member_count)
);
